FILE: design/crl_pkg.sv
// crl_pkg: shared types and constants for the row log-likelihood accumulator
// controller command/status structs, register indexes, fixed field constants
// no dependencies

package crl_pkg;

  // row clusters scored per row never exceed this (row_cluster is 4 bits)
  localparam int EMIT_LIMIT = 16;
  localparam int ACC_W      = 36;
  localparam int LP_W       = 24;

  // table code that marks a zero probability
  localparam logic [LP_W-1:0] ZERO_PROB_CODE = 24'h800000;
  // log(0.01) in Q8.16, that is -301805
  localparam logic [LP_W-1:0] ZERO_LOG_RESET = 24'hFB6513;

  localparam logic [ACC_W-1:0] ACC_MAX = 36'h7FFFFFFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 36'h800000000;

  // item kinds
  localparam logic CMD_TABLE_WR = 1'b0;
  localparam logic CMD_CELL     = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_ROW_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_NUM_CATEGORIES   = 2'd1;
  localparam logic [1:0] REG_ZERO_LOG_VALUE   = 2'd2;

  typedef struct packed {
    logic       capture;    // latch the accepted item
    logic       mem_wr;     // write the held table entry
    logic       rd_en;      // read table entry for row cluster rd_idx
    logic [3:0] rd_idx;
    logic       out_load;   // load output register from accumulator out_idx
    logic [3:0] out_idx;
    logic       out_last;
    logic       clear_all;  // clear every accumulator
  } crl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic cell_hit;         // data cell that adds into the accumulators
    logic last_of_row;
  } crl_sts_t;

endpackage

FILE: design/crl_in_if.sv
// crl_in_if: input channel of the row log-likelihood accumulator
// valid/ready handshake with table-write and data-cell payload
// no dependencies

interface crl_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [3:0]         row_cluster;
  logic [3:0]         col_cluster;
  logic [4:0]         category;
  logic signed [23:0] log_prob;
  logic               last_of_row;

  modport source (
    output valid, cmd, row_cluster, col_cluster, category, log_prob, last_of_row,
    input  ready
  );
  modport sink (
    input  valid, cmd, row_cluster, col_cluster, category, log_prob, last_of_row,
    output ready
  );
endinterface

FILE: design/crl_out_if.sv
// crl_out_if: result channel of the row log-likelihood accumulator
// valid/ready handshake carrying one row-cluster score per transaction
// no dependencies

interface crl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cluster_index;
  logic signed [35:0] score;
  logic               last;

  modport source (
    output valid, cluster_index, score, last,
    input  ready
  );
  modport sink (
    input  valid, cluster_index, score, last,
    output ready
  );
endinterface

FILE: design/crl_ctrl.sv
// crl_ctrl: sequencer for table writes, per-cluster accumulation and score emission
// depends on crl_pkg (command and status structs)

module crl_ctrl #(
  parameter int MAX_ROW_CLUSTERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  logic [4:0]        num_row_clusters,
  input  crl_pkg::crl_sts_t sts,
  output crl_pkg::crl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RUN,
    S_DRAIN,
    S_LOAD,
    S_SEND
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [4:0] n_min, n_act;
  logic [3:0] last_k;

  // active cluster count: 0 acts as 1, capped by storage and emit limit
  always_comb begin
    n_min = (num_row_clusters == 5'd0) ? 5'd1 : num_row_clusters;
    n_act = n_min;
    if (int'(n_min) > MAX_ROW_CLUSTERS) begin
      n_act = 5'(MAX_ROW_CLUSTERS);
    end
    if (int'(n_act) > crl_pkg::EMIT_LIMIT) begin
      n_act = 5'(crl_pkg::EMIT_LIMIT);
    end
  end

  assign last_k    = 4'(n_act - 5'd1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.rd_idx    = cnt_r;
    cmd.out_idx   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_nxt = 4'd0;
        if (sts.is_write) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.cell_hit) begin
          state_nxt = S_RUN;
        end else if (sts.last_of_row) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == last_k) begin
          cnt_nxt   = 4'd0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DRAIN: begin
        // last read lands in its accumulator here
        state_nxt = sts.last_of_row ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        cmd.out_load  = 1'b1;
        cmd.out_last  = (cnt_r == last_k);
        out_valid_nxt = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        cmd.out_idx  = cnt_r + 4'd1;
        cmd.out_last = ((cnt_r + 4'd1) == last_k);
        if (out_ready) begin
          if (cnt_r == last_k) begin
            out_valid_nxt = 1'b0;
            cmd.clear_all = 1'b1;
            cnt_nxt       = 4'd0;
            state_nxt     = S_IDLE;
          end else begin
            cmd.out_load = 1'b1;
            cnt_nxt      = cnt_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/crl_dp.sv
// crl_dp: datapath with log table memory, row-cluster accumulators and output register
// depends on crl_pkg (command and status structs, constants)

module crl_dp #(
  parameter int MAX_ROW_CLUSTERS = 16,
  parameter int MAX_COL_CLUSTERS = 16,
  parameter int MAX_CATEGORIES   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_cmd,
  input  logic [3:0]        in_row_cluster,
  input  logic [3:0]        in_col_cluster,
  input  logic [4:0]        in_category,
  input  logic [23:0]       in_log_prob,
  input  logic              in_last_of_row,
  input  logic [4:0]        num_categories,
  input  logic [23:0]       zero_log_value,
  input  crl_pkg::crl_cmd_t cmd,
  output crl_pkg::crl_sts_t sts,
  output logic [3:0]        out_cluster_index,
  output logic [35:0]       out_score,
  output logic              out_last
);

  localparam int DEPTH = MAX_ROW_CLUSTERS * MAX_COL_CLUSTERS * MAX_CATEGORIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] addr_of(logic [3:0] k, logic [3:0] cc,
                                            logic [4:0] cat);
    logic [AW-1:0] a;
    a = AW'(k) * AW'(MAX_COL_CLUSTERS * MAX_CATEGORIES)
      + AW'(cc) * AW'(MAX_CATEGORIES)
      + AW'(cat - 5'd1);
    return a;
  endfunction

  // held item
  logic        cmd_r;
  logic [3:0]  rc_r, cc_r;
  logic [4:0]  cat_r;
  logic [23:0] lp_r;
  logic        last_r;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_r;
  logic        acc_pend_r;
  logic [3:0]  acc_idx_r;
  logic [35:0] acc_r [crl_pkg::EMIT_LIMIT];

  logic        write_ok, cat_ok;
  logic [3:0]  acc_sel;
  logic [35:0] acc_cur;
  logic [23:0] entry;
  logic [36:0] sum;
  logic [35:0] sat;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      rc_r   <= in_row_cluster;
      cc_r   <= in_col_cluster;
      cat_r  <= in_category;
      lp_r   <= in_log_prob;
      last_r <= in_last_of_row;
    end
  end

  assign cat_ok   = (cat_r != 5'd0) && (int'(cat_r) <= MAX_CATEGORIES);
  assign write_ok = (int'(rc_r) < MAX_ROW_CLUSTERS) && (int'(cc_r) < MAX_COL_CLUSTERS)
                    && cat_ok;

  assign sts.is_write    = (cmd_r == crl_pkg::CMD_TABLE_WR);
  assign sts.cell_hit    = (cmd_r == crl_pkg::CMD_CELL) && (int'(cc_r) < MAX_COL_CLUSTERS)
                           && cat_ok && (cat_r <= num_categories);
  assign sts.last_of_row = last_r;

  // table memory, one access per cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && write_ok) begin
      mem[addr_of(rc_r, cc_r, cat_r)] <= lp_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr_of(cmd.rd_idx, cc_r, cat_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pend_r <= 1'b0;
    end else begin
      acc_pend_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      acc_idx_r <= cmd.rd_idx;
    end
  end

  // accumulation and output load never overlap, so one read port serves both
  assign acc_sel = cmd.out_load ? cmd.out_idx : acc_idx_r;
  assign acc_cur = acc_r[acc_sel];

  // zero-probability substitution and saturating add
  always_comb begin
    entry = (rd_data_r == crl_pkg::ZERO_PROB_CODE) ? zero_log_value : rd_data_r;
    sum   = {acc_cur[35], acc_cur} + {{13{entry[23]}}, entry};
    if (sum[36] != sum[35]) begin
      sat = sum[36] ? crl_pkg::ACC_MIN : crl_pkg::ACC_MAX;
    end else begin
      sat = sum[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      for (int i = 0; i < crl_pkg::EMIT_LIMIT; i++) begin
        acc_r[i] <= '0;
      end
    end else if (acc_pend_r) begin
      acc_r[acc_idx_r] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cluster_index <= cmd.out_idx;
      out_score         <= acc_cur;
      out_last          <= cmd.out_last;
    end
  end

endmodule

FILE: design/coclust_row_loglik_accumulator_unit.sv
// coclust_row_loglik_accumulator_unit: top level, configuration registers and glue
// depends on crl_pkg, crl_in_if, crl_out_if, crl_ctrl, crl_dp
//
//   channel   | direction | handshake            | carries
//   ----------+-----------+----------------------+----------------------------------
//   in_ch     | in        | valid/ready          | table write or one data cell
//   out_ch    | out       | valid/ready          | one row-cluster score per transaction
//   APB port  | in        | psel/penable, pready | num_row_clusters, num_categories,
//             |           |                      | zero_log_value at 0x0, 0x4, 0x8
//
// a table write passes through decode back to idle; a cell that adds reads the table once
// per active row cluster (n of them), since the single table read port serves one row cluster
// per cycle; a cell that adds nothing returns to idle after decode; a row's last cell then adds
// an output load plus n output transactions, one per cycle when out_ch.ready stays high
// one item is in flight at a time: in_ch.ready is low from accept until its scores are out
// synchronous active-low reset clears control state and the accumulators; the table
// memory is not cleared and must be written before it is read

module coclust_row_loglik_accumulator_unit #(
  parameter int MAX_ROW_CLUSTERS = 16,
  parameter int MAX_COL_CLUSTERS = 16,
  parameter int MAX_CATEGORIES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  crl_in_if.sink      in_ch,
  crl_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [4:0]  num_row_clusters_r;
  logic [4:0]  num_categories_r;
  logic [23:0] zero_log_value_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  crl_pkg::crl_cmd_t cmd;
  crl_pkg::crl_sts_t sts;
  logic [35:0]       score_raw;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_row_clusters_r <= 5'd1;
      num_categories_r   <= 5'd2;
      zero_log_value_r   <= crl_pkg::ZERO_LOG_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        crl_pkg::REG_NUM_ROW_CLUSTERS: num_row_clusters_r <= pwdata[4:0];
        crl_pkg::REG_NUM_CATEGORIES:   num_categories_r   <= pwdata[4:0];
        crl_pkg::REG_ZERO_LOG_VALUE:   zero_log_value_r   <= pwdata[23:0];
        default: begin
          // unmapped address, write dropped
        end
      endcase
    end
  end

  // read back, zero_log_value sign-extended to the bus
  always_comb begin
    case (reg_idx)
      crl_pkg::REG_NUM_ROW_CLUSTERS: prdata = {27'd0, num_row_clusters_r};
      crl_pkg::REG_NUM_CATEGORIES:   prdata = {27'd0, num_categories_r};
      crl_pkg::REG_ZERO_LOG_VALUE:   prdata = {{8{zero_log_value_r[23]}}, zero_log_value_r};
      default:                       prdata = 32'd0;
    endcase
  end

  // sequencer: decides per item which table reads, writes and emits happen
  crl_ctrl #(
    .MAX_ROW_CLUSTERS (MAX_ROW_CLUSTERS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .num_row_clusters (num_row_clusters_r),
    .sts              (sts),
    .cmd              (cmd)
  );

  // datapath: table memory, saturating accumulators, output register
  crl_dp #(
    .MAX_ROW_CLUSTERS (MAX_ROW_CLUSTERS),
    .MAX_COL_CLUSTERS (MAX_COL_CLUSTERS),
    .MAX_CATEGORIES   (MAX_CATEGORIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_ch.cmd),
    .in_row_cluster    (in_ch.row_cluster),
    .in_col_cluster    (in_ch.col_cluster),
    .in_category       (in_ch.category),
    .in_log_prob       (in_ch.log_prob),
    .in_last_of_row    (in_ch.last_of_row),
    .num_categories    (num_categories_r),
    .zero_log_value    (zero_log_value_r),
    .cmd               (cmd),
    .sts               (sts),
    .out_cluster_index (out_ch.cluster_index),
    .out_score         (score_raw),
    .out_last          (out_ch.last)
  );

  assign out_ch.score = score_raw;

  // no new item is taken while scores are being delivered
  a_no_accept_during_emit: assert property (
    @(posedge clk) disable iff (!rst_n) !(out_ch.valid && in_ch.ready)
  ) else $error("input ready while scores pending");

  // the row's final score ends the burst
  a_last_ends_burst: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid
  ) else $error("output valid after last score");

  // scores of one row come out in cluster order without gaps
  a_cluster_order: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=>
      (out_ch.valid && out_ch.cluster_index == $past(out_ch.cluster_index) + 4'd1)
  ) else $error("cluster index out of sequence");

  // first score of a burst is cluster zero
  a_burst_starts_at_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> (out_ch.cluster_index == 4'd0)
  ) else $error("score burst does not start at cluster zero");

endmodule

FILE: bench/tb_coclust_row_loglik_accumulator_unit.sv
`timescale 1ns / 1ps
// tb_coclust_row_loglik_accumulator_unit: self-checking bench for the row log-likelihood unit
// drives table writes and row cells, predicts every row-cluster score and checks it on out_ch
// depends on crl_pkg, crl_in_if, crl_out_if and coclust_row_loglik_accumulator_unit

module tb_coclust_row_loglik_accumulator_unit;

  // table geometry of the default build
  localparam int ROWC      = 16;
  localparam int COLC      = 16;
  localparam int CATS      = 16;
  localparam int TBL_DEPTH = ROWC * COLC * CATS;
  // cycle budget for the whole run
  localparam int LIMIT     = 600000;
  // cycles to let a cell that emits nothing finish before touching registers
  localparam int SETTLE    = 64;
  // cells in the row that mixes the zero code with a full-scale positive entry
  localparam int ROW_CELLS = 4;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  row_cluster;
    logic [3:0]  col_cluster;
    logic [4:0]  category;
    logic [23:0] log_prob;
    logic        last_of_row;
  } cell_item_t;

  typedef struct packed {
    logic [3:0]  cluster_index;
    logic [35:0] score;
    logic        last;
  } row_score_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crl_in_if  in_ch ();
  crl_out_if out_ch ();

  coclust_row_loglik_accumulator_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // scoring state: our own copy of the log table, accumulators and registers
  // ---------------------------------------------------------------------------
  logic [23:0] lp_table [TBL_DEPTH];
  logic [35:0] row_acc [ROWC];
  logic [4:0]  cfg_nrc  = 5'd1;
  logic [4:0]  cfg_ncat = 5'd2;
  logic [23:0] cfg_zlog = crl_pkg::ZERO_LOG_RESET;

  // which table entries the queued stimulus has written, so no cell reads a blank entry
  bit          tbl_set [TBL_DEPTH];

  cell_item_t  item_q [$];        // items waiting for the driver
  row_score_t  want_scores [$];   // scores owed by the block, oldest first
  int          pushed_n;
  int          accepted_n;
  int          fail_count;
  int          cycles;
  bit          no_idle;           // set for the last part of the run

  // driver / monitor working state
  cell_item_t  cur;
  logic        drv_nx;
  int          gap_left;
  int          stall_left;
  row_score_t  got;

  function automatic int active_rows();
    int n;
    n = cfg_nrc;
    if (n == 0) n = 1;
    if (n > ROWC) n = ROWC;
    return n;
  endfunction

  function automatic int cat_limit();
    return (cfg_ncat > CATS) ? CATS : int'(cfg_ncat);
  endfunction

  function automatic int tbl_index(int rc, int cc, int cat);
    return (rc * COLC + cc) * CATS + (cat - 1);
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // apply one accepted item to the scoring state, queue the row's scores on its last cell
  function automatic void score_item(cell_item_t it);
    int          n;
    int          k;
    logic [23:0] ent;
    logic [36:0] sum;
    row_score_t  rs;
    n = active_rows();
    if (it.cmd == crl_pkg::CMD_TABLE_WR) begin
      // writes outside the category range fall off the table
      if (it.category >= 1 && it.category <= CATS)
        lp_table[tbl_index(it.row_cluster, it.col_cluster, it.category)] = it.log_prob;
    end else begin
      if (it.category >= 1 && it.category <= cat_limit()) begin
        for (k = 0; k < n; k++) begin
          ent = lp_table[tbl_index(k, it.col_cluster, it.category)];
          // zero-probability code reads back as the zero-log register
          if (ent == crl_pkg::ZERO_PROB_CODE) ent = cfg_zlog;
          sum = {row_acc[k][35], row_acc[k]} + {{13{ent[23]}}, ent};
          // clamp to the 36-bit signed range
          if (sum[36] != sum[35]) row_acc[k] = sum[36] ? crl_pkg::ACC_MIN : crl_pkg::ACC_MAX;
          else row_acc[k] = sum[35:0];
        end
      end
      if (it.last_of_row) begin
        for (k = 0; k < n; k++) begin
          rs.cluster_index = 4'(k);
          rs.score         = row_acc[k];
          rs.last          = (k == n - 1);
          want_scores      = {want_scores, rs};
        end
        for (k = 0; k < ROWC; k++) row_acc[k] = '0;
      end
    end
  endfunction

  function automatic void check_score(row_score_t s);
    row_score_t want;
    if (want_scores.size() == 0) begin
      note_fail($sformatf("unexpected score: cluster %0d score %0d last %0b",
                          s.cluster_index, $signed(s.score), s.last));
    end else begin
      want = want_scores.pop_front();
      if (s.cluster_index !== want.cluster_index || s.score !== want.score ||
          s.last !== want.last)
        note_fail($sformatf("score mismatch: exp cluster %0d score %0d last %0b, got %0d %0d %0b",
                            want.cluster_index, $signed(want.score), want.last,
                            s.cluster_index, $signed(s.score), s.last));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] rand_lp();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0: v = crl_pkg::ZERO_PROB_CODE;
      1: v = 24'($urandom_range(1, 8388607));   // positive entry, added as given
      2: v = '0;
      3: v = 24'h800001;                        // most negative ordinary value
      default: v = -24'($urandom_range(0, 8388607));
    endcase
    return v;
  endfunction

  function automatic void push_write(int rc, int cc, int cat, logic [23:0] lp, logic last);
    cell_item_t it;
    it.cmd         = crl_pkg::CMD_TABLE_WR;
    it.row_cluster = 4'(rc);
    it.col_cluster = 4'(cc);
    it.category    = 5'(cat);
    it.log_prob    = lp;
    it.last_of_row = last;
    if (cat >= 1 && cat <= CATS) tbl_set[tbl_index(rc, cc, cat)] = 1'b1;
    item_q = {item_q, it};
    pushed_n++;
  endfunction

  // a cell that adds first gets every table entry it will read written
  function automatic void push_cell(int cc, int cat, logic last);
    cell_item_t it;
    int         n;
    int         k;
    n = active_rows();
    if (cat >= 1 && cat <= cat_limit()) begin
      for (k = 0; k < n; k++)
        if (!tbl_set[tbl_index(k, cc, cat)])
          push_write(k, cc, cat, rand_lp(), 1'($urandom_range(0, 1)));
    end
    it.cmd         = crl_pkg::CMD_CELL;
    it.row_cluster = 4'($urandom_range(0, 15));   // unused by cells
    it.col_cluster = 4'(cc);
    it.category    = 5'(cat);
    it.log_prob    = 24'($urandom);               // unused by cells
    it.last_of_row = last;
    item_q = {item_q, it};
    pushed_n++;
  endfunction

  // random rows; mostly cells that add, some out-of-range cells and stray table writes
  task automatic random_rows(input int target);
    int start;
    int rows;
    int len;
    int j;
    int lim;
    int cc;
    int cat;
    bit fin;
    start = pushed_n;
    rows  = 0;
    while (pushed_n - start < target || rows < 2) begin
      len = $urandom_range(1, 6);
      lim = cat_limit();
      for (j = 0; j < len; j++) begin
        fin = (j == len - 1);
        cc  = $urandom_range(0, 15);
        case ($urandom_range(0, 7))
          0: begin
            if (!fin)
              push_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
                         rand_lp(), 1'($urandom_range(0, 1)));
            else
              push_cell(cc, 0, 1'b1);
          end
          1: begin
            // category zero or above the active count
            cat = $urandom_range(lim, 31);
            if (cat == lim) cat = 0;
            push_cell(cc, cat, fin);
          end
          default: begin
            // adding cells stay on column cluster 0, categories 1..2, so table fills stay few
            cat = (lim == 0) ? 0 : $urandom_range(1, (lim > 2) ? 2 : lim);
            push_cell((cat == 0) ? cc : 0, cat, fin);
          end
        endcase
      end
      rows++;
    end
  endtask

  // wait for every queued item to be taken and every score to arrive, then let the unit settle
  task automatic drain();
    while (accepted_n != pushed_n) @(posedge clk);
    while (want_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    // register takes the value at the edge where the access phase meets pready
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      crl_pkg::REG_NUM_ROW_CLUSTERS: cfg_nrc  = value[4:0];
      crl_pkg::REG_NUM_CATEGORIES:   cfg_ncat = value[4:0];
      crl_pkg::REG_ZERO_LOG_VALUE:   cfg_zlog = value[23:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int nrc, input int ncat, input int zlog);
    cfg_write(crl_pkg::REG_NUM_ROW_CLUSTERS, 32'(nrc));
    cfg_write(crl_pkg::REG_NUM_CATEGORIES, 32'(ncat));
    cfg_write(crl_pkg::REG_ZERO_LOG_VALUE, 32'(zlog));
  endtask

  // ---------------------------------------------------------------------------
  // driver: one transaction at a time from item_q, random idle bursts between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_nx = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        score_item(cur);
        accepted_n++;
        drv_nx = 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
      end
      if (!drv_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q.size() != 0) begin
          cur = item_q.pop_front();
          in_ch.cmd         <= cur.cmd;
          in_ch.row_cluster <= cur.row_cluster;
          in_ch.col_cluster <= cur.col_cluster;
          in_ch.category    <= cur.category;
          in_ch.log_prob    <= cur.log_prob;
          in_ch.last_of_row <= cur.last_of_row;
          drv_nx = 1'b1;
        end
      end
      // single update of valid per edge, so back-to-back items keep it high
      in_ch.valid <= drv_nx;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each score transaction, stalls ready in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.cluster_index, out_ch.score, out_ch.last};
        check_score(got);
      end
      if (stall_left > 0) stall_left--;
      else if (!no_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      out_ch.ready <= (stall_left == 0);
    end
  end

  // run budget
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_coclust_row_loglik_accumulator_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = crl_pkg::CMD_TABLE_WR;
    in_ch.row_cluster = '0;
    in_ch.col_cluster = '0;
    in_ch.category    = '0;
    in_ch.log_prob    = '0;
    in_ch.last_of_row = 1'b0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_n             = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: one row cluster, categories 1..2, zero-log of log(0.01)
    push_write(0, 0, 1, crl_pkg::ZERO_PROB_CODE, 1'b1);   // last flag on a write is ignored
    push_write(0, 0, 2, 24'h800001, 1'b0);
    push_write(3, 2, 0, 24'h123456, 1'b0);      // category zero: dropped
    push_write(5, 1, 17, 24'h0F0F0F, 1'b0);     // category past the table: dropped
    push_write(15, 15, 31, '0, 1'b1);           // dropped too
    push_cell(0, 1, 1'b0);                       // reads the zero-log register
    push_cell(0, 2, 1'b0);
    push_cell(0, 0, 1'b0);                       // category zero adds nothing
    push_cell(0, 3, 1'b0);                       // above num_categories adds nothing
    push_cell(0, 1, 1'b1);
    push_cell(9, 0, 1'b1);                       // lone out-of-range last cell still emits
    drain();

    // four clusters, category count above the table cut to 16, zero-log of zero
    apply_setting(4, 31, 0);
    push_write(0, 15, 16, crl_pkg::ZERO_PROB_CODE, 1'b0);
    push_write(1, 15, 16, '0, 1'b0);
    push_write(2, 15, 16, 24'h7FFFFF, 1'b0);
    push_write(3, 15, 16, 24'hFFFFFF, 1'b0);
    push_cell(15, 16, 1'b0);
    push_cell(15, 17, 1'b0);
    push_cell(15, 31, 1'b0);
    push_cell(15, 16, 1'b1);
    drain();

    // short row: cluster 0 reads the zero code at a zero-log of -8388607,
    // cluster 1 a full-scale positive entry
    apply_setting(2, 16, -8388607);
    push_write(0, 7, 5, crl_pkg::ZERO_PROB_CODE, 1'b0);
    push_write(1, 7, 5, 24'h7FFFFF, 1'b0);
    for (i = 0; i < ROW_CELLS; i++) push_cell(7, 5, i == ROW_CELLS - 1);
    drain();

    // random rows under a spread of settings; each phase ends idle
    apply_setting(0, 1, -8388607);               // zero clusters act as one
    random_rows(10);
    drain();
    apply_setting(31, 31, 0);                    // both counts cut to 16
    random_rows(10);
    drain();
    apply_setting(7, 5, -int'($urandom_range(1, 8388607)));
    random_rows(10);
    drain();
    apply_setting(3, 0, -8388608);               // no valid category at all
    random_rows(10);
    drain();

    no_idle = 1'b1;
    apply_setting(16, 16, -301805);
    random_rows(10);
    drain();

    if (fail_count == 0) begin
      $display("tb_coclust_row_loglik_accumulator_unit OK");
    end else begin
      $display("tb_coclust_row_loglik_accumulator_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/crl_pkg.sv
design/crl_in_if.sv
design/crl_out_if.sv
design/crl_ctrl.sv
design/crl_dp.sv
design/coclust_row_loglik_accumulator_unit.sv
bench/tb_coclust_row_loglik_accumulator_unit.sv
